### rtl/aqg_pkg.sv
// Shared types and constants of the adaptive quality governor.
package aqg_pkg;

    localparam int RATE_W    = 16;
    localparam int LEVEL_W   = 7;
    localparam int THETA_W   = 8;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_DROP_FLOOR = 7'd10;
    localparam logic [LEVEL_W-1:0] COLLISION_CUT    = 7'd50;
    localparam logic [THETA_W-1:0] THETA_RISE       = 8'd10;
    localparam logic [THETA_W-1:0] THETA_FALL       = 8'd5;
    localparam logic [THETA_W-1:0] THETA_CEIL       = 8'd200;
    localparam logic [THETA_W-1:0] THETA_FLOOR      = 8'd30;
    localparam logic [THETA_W-1:0] THETA_RESET      = 8'd50;
    localparam logic [THETA_W-1:0] THETA_BASE       = 8'd50;

    localparam logic [RATE_W-1:0]  LOW_THR_RESET  = 16'd880;
    localparam logic [RATE_W-1:0]  HIGH_THR_RESET = 16'd1040;
    localparam logic [COUNT_W-1:0] ADJUST_RESET   = 8'd30;
    localparam logic [LEVEL_W-1:0] STEP_RESET     = 7'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_LOW_THR  = 3'd1,
        REG_HIGH_THR = 3'd2,
        REG_ADJUST   = 3'd3,
        REG_STEP     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                 enable;
        logic [RATE_W-1:0]    low_thr;
        logic [RATE_W-1:0]    high_thr;
        logic [COUNT_W-1:0]   adjust_frames;
        logic [LEVEL_W-1:0]   step;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_W-1:0]   frame_counter;
        logic [LEVEL_W-1:0]   force_q;
        logic [LEVEL_W-1:0]   collision_q;
        logic [LEVEL_W-1:0]   particle_q;
        logic [THETA_W-1:0]   theta;
    } t_state;

    typedef struct packed {
        logic [LEVEL_W-1:0]   force_level;
        logic [LEVEL_W-1:0]   collision_level;
        logic [LEVEL_W-1:0]   particle_level;
        logic [THETA_W-1:0]   theta_level;
        logic [THETA_W-1:0]   theta_applied;
        logic                 collision_on;
        logic                 evaluated;
    } t_result;

endpackage

### rtl/aqg_cfg.sv
// Configuration register file of the adaptive quality governor.
module aqg_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [aqg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aqg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output aqg_pkg::t_cfg                   o_cfg
);
    import aqg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b1;
            r_cfg.low_thr       <= LOW_THR_RESET;
            r_cfg.high_thr      <= HIGH_THR_RESET;
            r_cfg.adjust_frames <= ADJUST_RESET;
            r_cfg.step          <= STEP_RESET;
        end else if (i_cfg_valid) begin
            // Writes to indexes beyond the register list are dropped.
            unique case (i_cfg_index)
                REG_ENABLE:   r_cfg.enable        <= i_cfg_data[0];
                REG_LOW_THR:  r_cfg.low_thr       <= i_cfg_data[RATE_W-1:0];
                REG_HIGH_THR: r_cfg.high_thr      <= i_cfg_data[RATE_W-1:0];
                REG_ADJUST:   r_cfg.adjust_frames <= i_cfg_data[COUNT_W-1:0];
                REG_STEP:     r_cfg.step          <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/aqg_update.sv
// Per-frame next-state and result logic of the adaptive quality governor.
module aqg_update (
    input  aqg_pkg::t_cfg                 i_cfg,
    input  aqg_pkg::t_state               i_state,
    input  logic [aqg_pkg::RATE_W-1:0]    i_rate,
    output aqg_pkg::t_state               o_state,
    output aqg_pkg::t_result              o_result
);
    import aqg_pkg::*;

    function automatic logic [LEVEL_W-1:0] level_down(
        input logic [LEVEL_W-1:0] lvl, input logic [LEVEL_W-1:0] step);
        logic [LEVEL_W-1:0] res;
        res = lvl;
        if (lvl > LEVEL_DROP_FLOOR) begin
            res = (lvl > step) ? (lvl - step) : '0;
        end
        return res;
    endfunction

    function automatic logic [LEVEL_W-1:0] level_up(
        input logic [LEVEL_W-1:0] lvl, input logic [LEVEL_W-1:0] step);
        logic [LEVEL_W:0] sum;
        sum = {1'b0, lvl};
        if (lvl < LEVEL_MAX) begin
            sum = {1'b0, lvl} + {1'b0, step};
        end
        return (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[LEVEL_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lvl);
        return (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
    endfunction

    logic [COUNT_W-1:0] count_inc;
    logic               do_eval;
    logic               go_down;
    logic               go_up;
    logic [THETA_W-1:0] theta_up;
    logic [LEVEL_W-1:0] force_gap;
    t_state             nxt;

    always_comb begin
        count_inc = i_state.frame_counter + 1'b1;
        do_eval   = i_cfg.enable && (count_inc >= i_cfg.adjust_frames);
        go_down   = i_rate < i_cfg.low_thr;
        go_up     = !go_down && (i_rate > i_cfg.high_thr);
        theta_up  = i_state.theta + THETA_RISE;

        nxt = i_state;
        if (i_cfg.enable) begin
            nxt.frame_counter = count_inc;
        end
        if (do_eval) begin
            nxt.frame_counter = '0;
            priority if (go_down) begin
                nxt.force_q     = level_down(i_state.force_q, i_cfg.step);
                nxt.collision_q = level_down(i_state.collision_q, i_cfg.step);
                nxt.particle_q  = level_down(i_state.particle_q, i_cfg.step);
                nxt.theta       = (theta_up > THETA_CEIL) ? THETA_CEIL : theta_up;
            end else if (go_up) begin
                nxt.force_q     = level_up(i_state.force_q, i_cfg.step);
                nxt.collision_q = level_up(i_state.collision_q, i_cfg.step);
                nxt.particle_q  = level_up(i_state.particle_q, i_cfg.step);
                nxt.theta       = (i_state.theta < THETA_FLOOR + THETA_FALL) ?
                                  THETA_FLOOR : (i_state.theta - THETA_FALL);
            end else begin
                nxt.theta = i_state.theta;
            end
            nxt.force_q     = clamp_level(nxt.force_q);
            nxt.collision_q = clamp_level(nxt.collision_q);
            nxt.particle_q  = clamp_level(nxt.particle_q);
        end

        force_gap = LEVEL_MAX - nxt.force_q;

        o_state                  = nxt;
        o_result.force_level     = nxt.force_q;
        o_result.collision_level = nxt.collision_q;
        o_result.particle_level  = nxt.particle_q;
        o_result.theta_level     = nxt.theta;
        o_result.theta_applied   = (nxt.force_q < LEVEL_MAX) ?
                                   (THETA_BASE + {force_gap, 1'b0}) : nxt.theta;
        o_result.collision_on    = nxt.collision_q >= COLLISION_CUT;
        o_result.evaluated       = do_eval;
    end

endmodule

### rtl/adaptive_quality_governor_unit.sv
// Top level of the adaptive quality governor: input register, update logic, result register.
//
//  Channel  Direction  Handshake                    Payload
//  in       in         i_in_valid / o_in_ready      i_frame_rate
//  cfg      in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//  out      out        o_out_valid / i_out_ready    levels, theta, collision_on, evaluated
//
// Each frame passes from acceptance through the input register, then through the update
// logic into the result register, where the governor state is also written. A new frame
// transaction is accepted every cycle while the output does not stall; the rate is set by
// the state update loop. Synchronous active-low reset restores the register defaults,
// clears the frame counter and sets all levels to 100 and theta to 50. When the
// result is not taken, the input register still accepts one more transaction before
// o_in_ready falls. Configuration transactions are always accepted.
module adaptive_quality_governor_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [aqg_pkg::RATE_W-1:0]      i_frame_rate,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [aqg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aqg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [aqg_pkg::LEVEL_W-1:0]     o_force_level,
    output logic [aqg_pkg::LEVEL_W-1:0]     o_collision_level,
    output logic [aqg_pkg::LEVEL_W-1:0]     o_particle_level,
    output logic [aqg_pkg::THETA_W-1:0]     o_theta_level,
    output logic [aqg_pkg::THETA_W-1:0]     o_theta_applied,
    output logic                            o_collision_on,
    output logic                            o_evaluated
);
    import aqg_pkg::*;

    t_cfg               cfg;
    logic               r_s1_valid;
    logic [RATE_W-1:0]  r_s1_rate;
    t_state             r_state;
    t_state             n_state;
    logic               r_out_valid;
    t_result            r_result;
    t_result            n_result;
    logic               s2_fire;

    aqg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    aqg_update u_update (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_rate   (r_s1_rate),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // The held frame moves on whenever the result register is empty or being drained.
    assign s2_fire     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s2_fire;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_state.frame_counter <= '0;
            r_state.force_q       <= LEVEL_MAX;
            r_state.collision_q   <= LEVEL_MAX;
            r_state.particle_q    <= LEVEL_MAX;
            r_state.theta         <= THETA_RESET;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_rate <= i_frame_rate;
        end
        if (s2_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_force_level     = r_result.force_level;
    assign o_collision_level = r_result.collision_level;
    assign o_particle_level  = r_result.particle_level;
    assign o_theta_level     = r_result.theta_level;
    assign o_theta_applied   = r_result.theta_applied;
    assign o_collision_on    = r_result.collision_on;
    assign o_evaluated       = r_result.evaluated;

    // Input backpressure only arises when both stages are occupied and the output stalls.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input ready dropped without a full pipeline");

    // An evaluation always restarts the frame count.
    a_eval_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && n_result.evaluated) |=> (r_state.frame_counter == '0))
        else $error("frame counter not cleared after evaluation");

    // Stored theta stays inside its clamp limits.
    a_theta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.theta >= THETA_FLOOR) && (r_state.theta <= THETA_CEIL))
        else $error("stored theta out of range");

    // Quality levels never exceed the maximum.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.force_q <= LEVEL_MAX) && (r_state.collision_q <= LEVEL_MAX) &&
        (r_state.particle_q <= LEVEL_MAX))
        else $error("quality level above maximum");

endmodule
